// ===== hdl/vna_pkg.sv =====
// Shared types, codes and constants of the vertex normal accumulator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package vna_pkg;

   localparam int VERTEX_COUNT_DEF = 1024;

   localparam int IDX_W  = 10;
   localparam int POS_W  = 24;
   localparam int SIDE_W = 25;
   localparam int PROD_W = 50;
   localparam int ACC_W  = 60;
   localparam int SUM_W  = 50;
   localparam int ROOT_W = 63;
   localparam int LEN_W  = 31;
   localparam int NUM_W  = 46;
   localparam int QUO_W  = 16;
   localparam int NRM_W  = 16;
   localparam int CNT_W  = 5;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TRI  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]              mode;
      logic [IDX_W-1:0]        vertex_index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [IDX_W-1:0]        corner_a;
      logic [IDX_W-1:0]        corner_b;
      logic [IDX_W-1:0]        corner_c;
   } req_type;

   typedef struct packed {
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
      logic                    zero_length;
   } rsp_type;

   typedef enum logic [2:0] {
      ADDR_PORT = 3'd0,
      ADDR_VIDX = 3'd1,
      ADDR_CA   = 3'd2,
      ADDR_CB   = 3'd3,
      ADDR_CC   = 3'd4
   } addr_sel_type;

   typedef enum logic [3:0] {
      MS_NX0 = 4'd0,
      MS_NX1 = 4'd1,
      MS_NY0 = 4'd2,
      MS_NY1 = 4'd3,
      MS_NZ0 = 4'd4,
      MS_NZ1 = 4'd5,
      MS_SQX = 4'd6,
      MS_SQY = 4'd7,
      MS_SQZ = 4'd8
   } mul_step_type;

   typedef struct packed {
      logic         latch_req;
      logic         load_vertex;
      addr_sel_type addr_sel;
      logic         pos_rd;
      logic         cap_en;
      logic [1:0]   cap_sel;
      logic         side_load;
      logic         mul_en;
      mul_step_type mul_step;
      logic         fold_en;
      mul_step_type fold_step;
      logic         acc_rd;
      logic         acc_wr;
      logic         mag_load;
      logic         shift_en;
      logic         sqrt_init;
      logic         sqrt_step;
      logic         div_init;
      logic         div_step;
      logic         div_store;
      logic [1:0]   div_comp;
      logic         rsp_zero;
      logic         rsp_emit;
   } cmd_type;

   typedef struct packed {
      logic idx_bad;
      logic tri_bad;
      logic mag_big;
      logic sum_zero;
   } status_type;

   function automatic addr_sel_type corner_sel(input logic [1:0] k);
      addr_sel_type sel;
      case (k)
         2'd0:    sel = ADDR_CA;
         2'd1:    sel = ADDR_CB;
         default: sel = ADDR_CC;
      endcase
      return sel;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/vna_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/vna_datapath.sv =====
// Datapath: position and accumulator stores, cross product, saturating
// accumulate, normalize shift, square root and divide. Uses vna_pkg, vna_ram.
`default_nettype none

module vna_datapath #(
   parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire vna_pkg::req_type    req_item,
   input  wire vna_pkg::cmd_type    cmd,
   output vna_pkg::status_type      status,
   output logic                     rsp_strobe,
   output vna_pkg::rsp_type         rsp_item
);

   localparam int AW = $clog2(VERTEX_COUNT);
   localparam logic [16:0] VC_LIMIT = 17'(VERTEX_COUNT);
   localparam int PW = 3 * vna_pkg::POS_W;
   localparam int AWD = 3 * vna_pkg::ACC_W;

   vna_pkg::req_type req_ff;

   logic [AW-1:0]  addr;
   logic [PW-1:0]  pos_wdata;
   logic [PW-1:0]  pos_rdata;
   logic [AWD-1:0] acc_wdata;
   logic [AWD-1:0] acc_rdata;
   logic [AWD-1:0] acc_new;

   logic signed [vna_pkg::POS_W-1:0]  pt_ff [3][3];
   logic signed [vna_pkg::SIDE_W-1:0] s1_ff [3];
   logic signed [vna_pkg::SIDE_W-1:0] s2_ff [3];
   logic signed [vna_pkg::SIDE_W-1:0] mul_a;
   logic signed [vna_pkg::SIDE_W-1:0] mul_b;
   logic signed [vna_pkg::PROD_W-1:0] prod_ff;
   logic signed [vna_pkg::PROD_W-1:0] n_ff [3];
   logic [vna_pkg::SUM_W-1:0]         sum_ff;

   logic signed [vna_pkg::ACC_W-1:0] acc_old [3];
   logic [vna_pkg::ACC_W-1:0]        m_ff [3];
   logic [2:0]                       neg_ff;

   logic [vna_pkg::ROOT_W-1:0] rem_ff;
   logic [vna_pkg::ROOT_W-1:0] res_ff;
   logic [vna_pkg::ROOT_W-1:0] bit_ff;
   logic [vna_pkg::ROOT_W-1:0] trial;
   logic [vna_pkg::LEN_W-1:0]  len;

   logic [vna_pkg::NUM_W-1:0]  num_ff;
   logic [vna_pkg::NUM_W-1:0]  dvs_ff;
   logic [vna_pkg::QUO_W-1:0]  q_ff;
   logic [vna_pkg::POS_W-1:0]  m_div;
   logic                       neg_div;
   logic                       ge;
   logic [14:0]                q_clamp;
   logic [vna_pkg::NRM_W-1:0]  q_signed;
   logic [vna_pkg::NRM_W-1:0]  nout_ff [3];

   logic             rsp_valid_ff;
   vna_pkg::rsp_type rsp_ff;

   // port range checks, used when the item is accepted, and read-path flags
   always_comb begin
      status.idx_bad  = {7'd0, req_item.vertex_index} >= VC_LIMIT;
      status.tri_bad  = ({7'd0, req_item.corner_a} >= VC_LIMIT)
                     || ({7'd0, req_item.corner_b} >= VC_LIMIT)
                     || ({7'd0, req_item.corner_c} >= VC_LIMIT);
      status.mag_big  = (|m_ff[0][vna_pkg::ACC_W-1:vna_pkg::POS_W])
                     || (|m_ff[1][vna_pkg::ACC_W-1:vna_pkg::POS_W])
                     || (|m_ff[2][vna_pkg::ACC_W-1:vna_pkg::POS_W]);
      status.sum_zero = (sum_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_item;
      end
   end

   always_comb begin
      unique case (cmd.addr_sel)
         vna_pkg::ADDR_PORT: addr = AW'(req_item.vertex_index);
         vna_pkg::ADDR_VIDX: addr = AW'(req_ff.vertex_index);
         vna_pkg::ADDR_CA:   addr = AW'(req_ff.corner_a);
         vna_pkg::ADDR_CB:   addr = AW'(req_ff.corner_b);
         vna_pkg::ADDR_CC:   addr = AW'(req_ff.corner_c);
         default:            addr = '0;
      endcase
   end

   assign pos_wdata = {req_item.pos_z, req_item.pos_y, req_item.pos_x};

   vna_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
      .clock   (clock),
      .wr_en   (cmd.load_vertex),
      .wr_addr (addr),
      .wr_data (pos_wdata),
      .rd_en   (cmd.pos_rd),
      .rd_addr (addr),
      .rd_data (pos_rdata)
   );

   // saturating add of the cross product into each axis
   always_comb begin
      logic signed [vna_pkg::ACC_W:0] s;
      for (int k = 0; k < 3; k++) begin
         acc_old[k] = $signed(acc_rdata[k*vna_pkg::ACC_W +: vna_pkg::ACC_W]);
         s = 61'(acc_old[k]) + 61'(n_ff[k]);
         if (s[vna_pkg::ACC_W] != s[vna_pkg::ACC_W-1]) begin
            acc_new[k*vna_pkg::ACC_W +: vna_pkg::ACC_W] =
               s[vna_pkg::ACC_W] ? vna_pkg::ACC_MIN : vna_pkg::ACC_MAX;
         end else begin
            acc_new[k*vna_pkg::ACC_W +: vna_pkg::ACC_W] = s[vna_pkg::ACC_W-1:0];
         end
      end
   end

   assign acc_wdata = cmd.acc_wr ? acc_new : '0;

   vna_ram #(.WIDTH(AWD), .DEPTH(VERTEX_COUNT)) u_acc_ram (
      .clock   (clock),
      .wr_en   (cmd.load_vertex | cmd.acc_wr),
      .wr_addr (addr),
      .wr_data (acc_wdata),
      .rd_en   (cmd.acc_rd),
      .rd_addr (addr),
      .rd_data (acc_rdata)
   );

   // corner capture and triangle sides
   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         for (int ax = 0; ax < 3; ax++) begin
            case (cmd.cap_sel)
               2'd0:    pt_ff[0][ax] <= $signed(pos_rdata[ax*vna_pkg::POS_W +: vna_pkg::POS_W]);
               2'd1:    pt_ff[1][ax] <= $signed(pos_rdata[ax*vna_pkg::POS_W +: vna_pkg::POS_W]);
               default: pt_ff[2][ax] <= $signed(pos_rdata[ax*vna_pkg::POS_W +: vna_pkg::POS_W]);
            endcase
         end
      end
      if (cmd.side_load) begin
         for (int ax = 0; ax < 3; ax++) begin
            s1_ff[ax] <= 25'(pt_ff[2][ax]) - 25'(pt_ff[0][ax]);
            s2_ff[ax] <= 25'(pt_ff[1][ax]) - 25'(pt_ff[0][ax]);
         end
      end
   end

   // one shared multiplier: cross product terms, then squares
   always_comb begin
      unique case (cmd.mul_step)
         vna_pkg::MS_NX0: begin mul_a = s1_ff[1]; mul_b = s2_ff[2]; end
         vna_pkg::MS_NX1: begin mul_a = s1_ff[2]; mul_b = s2_ff[1]; end
         vna_pkg::MS_NY0: begin mul_a = s1_ff[2]; mul_b = s2_ff[0]; end
         vna_pkg::MS_NY1: begin mul_a = s1_ff[0]; mul_b = s2_ff[2]; end
         vna_pkg::MS_NZ0: begin mul_a = s1_ff[0]; mul_b = s2_ff[1]; end
         vna_pkg::MS_NZ1: begin mul_a = s1_ff[1]; mul_b = s2_ff[0]; end
         vna_pkg::MS_SQX: begin
            mul_a = $signed({1'b0, m_ff[0][vna_pkg::POS_W-1:0]});
            mul_b = mul_a;
         end
         vna_pkg::MS_SQY: begin
            mul_a = $signed({1'b0, m_ff[1][vna_pkg::POS_W-1:0]});
            mul_b = mul_a;
         end
         vna_pkg::MS_SQZ: begin
            mul_a = $signed({1'b0, m_ff[2][vna_pkg::POS_W-1:0]});
            mul_b = mul_a;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.fold_en) begin
         case (cmd.fold_step)
            vna_pkg::MS_NX0: n_ff[0] <= prod_ff;
            vna_pkg::MS_NX1: n_ff[0] <= n_ff[0] - prod_ff;
            vna_pkg::MS_NY0: n_ff[1] <= prod_ff;
            vna_pkg::MS_NY1: n_ff[1] <= n_ff[1] - prod_ff;
            vna_pkg::MS_NZ0: n_ff[2] <= prod_ff;
            vna_pkg::MS_NZ1: n_ff[2] <= n_ff[2] - prod_ff;
            vna_pkg::MS_SQX: sum_ff  <= $unsigned(prod_ff);
            default:         sum_ff  <= sum_ff + $unsigned(prod_ff);
         endcase
      end
   end

   // magnitudes and the common right shift
   always_ff @(posedge clock) begin
      if (cmd.mag_load) begin
         for (int k = 0; k < 3; k++) begin
            neg_ff[k] <= acc_old[k][vna_pkg::ACC_W-1];
            m_ff[k]   <= acc_old[k][vna_pkg::ACC_W-1]
                       ? (60'd0 - $unsigned(acc_old[k])) : $unsigned(acc_old[k]);
         end
      end else if (cmd.shift_en) begin
         for (int k = 0; k < 3; k++) begin
            m_ff[k] <= m_ff[k] >> 1;
         end
      end
   end

   // bit-pair square root of sum << 12, one pair per cycle
   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         rem_ff <= {1'b0, sum_ff, 12'd0};
         res_ff <= '0;
         bit_ff <= {1'b1, {(vna_pkg::ROOT_W-1){1'b0}}};
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign len = res_ff[vna_pkg::LEN_W-1:0];

   // restoring divide, quotient never exceeds 16 bits
   always_comb begin
      case (cmd.div_comp)
         2'd0:    begin m_div = m_ff[0][vna_pkg::POS_W-1:0]; neg_div = neg_ff[0]; end
         2'd1:    begin m_div = m_ff[1][vna_pkg::POS_W-1:0]; neg_div = neg_ff[1]; end
         default: begin m_div = m_ff[2][vna_pkg::POS_W-1:0]; neg_div = neg_ff[2]; end
      endcase
   end

   assign ge       = num_ff >= dvs_ff;
   assign q_clamp  = q_ff[15] ? 15'h7FFF : q_ff[14:0];
   assign q_signed = neg_div ? (16'd0 - {1'b0, q_clamp}) : {1'b0, q_clamp};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         num_ff <= 46'({m_div, 21'd0}) + 46'(len[vna_pkg::LEN_W-1:1]);
         dvs_ff <= {len, 15'd0};
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (ge) begin
            num_ff <= num_ff - dvs_ff;
         end
         q_ff   <= {q_ff[vna_pkg::QUO_W-2:0], ge};
         dvs_ff <= dvs_ff >> 1;
      end
      if (cmd.div_store) begin
         case (cmd.div_comp)
            2'd0:    nout_ff[0] <= q_signed;
            2'd1:    nout_ff[1] <= q_signed;
            default: nout_ff[2] <= q_signed;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_zero | cmd.rsp_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_zero) begin
         rsp_ff <= '{normal_x: '0, normal_y: '0, normal_z: '0, zero_length: 1'b1};
      end else if (cmd.rsp_emit) begin
         rsp_ff <= '{normal_x: nout_ff[0], normal_y: nout_ff[1],
                     normal_z: nout_ff[2], zero_length: 1'b0};
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/vna_controller.sv =====
// Controller state machine: sequences store accesses, multiplies,
// square root and divide steps. Uses vna_pkg.
`default_nettype none

module vna_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [1:0]          req_mode,
   input  wire vna_pkg::status_type status,
   output logic                     busy,
   output vna_pkg::cmd_type         cmd
);

   typedef enum logic [15:0] {
      S_IDLE      = 16'h0001,
      S_P_RD      = 16'h0002,
      S_SIDES     = 16'h0004,
      S_MUL       = 16'h0008,
      S_ACC_RD    = 16'h0010,
      S_ACC_WR    = 16'h0020,
      S_N_RD      = 16'h0040,
      S_N_MAG     = 16'h0080,
      S_N_SHIFT   = 16'h0100,
      S_N_SQ      = 16'h0200,
      S_N_CHK     = 16'h0400,
      S_N_SQRT    = 16'h0800,
      S_DIV_INIT  = 16'h1000,
      S_DIV       = 16'h2000,
      S_DIV_STORE = 16'h4000,
      S_N_OUT     = 16'h8000
   } state_type;

   state_type                  state_ff, state_in;
   logic [vna_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]                 k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.addr_sel  = vna_pkg::ADDR_PORT;
      cmd.mul_step  = vna_pkg::MS_NX0;
      cmd.fold_step = vna_pkg::MS_NX0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               cnt_in = '0;
               k_in   = '0;
               case (req_mode)
                  vna_pkg::MODE_LOAD: cmd.load_vertex = !status.idx_bad;
                  vna_pkg::MODE_TRI: begin
                     if (!status.tri_bad) begin
                        state_in = S_P_RD;
                     end
                  end
                  vna_pkg::MODE_READ: begin
                     if (status.idx_bad) begin
                        cmd.rsp_zero = 1'b1;
                     end else begin
                        state_in = S_N_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // read corners a, b, c; data lands in the next cycle
         S_P_RD: begin
            if (cnt_ff < 5'd3) begin
               cmd.pos_rd   = 1'b1;
               cmd.addr_sel = vna_pkg::corner_sel(cnt_ff[1:0]);
            end
            if (cnt_ff != 5'd0) begin
               cmd.cap_en  = 1'b1;
               cmd.cap_sel = cnt_ff[1:0] - 2'd1;
            end
            if (cnt_ff == 5'd3) begin
               state_in = S_SIDES;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_SIDES: begin
            cmd.side_load = 1'b1;
            cnt_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (cnt_ff < 5'd6) begin
               cmd.mul_en   = 1'b1;
               cmd.mul_step = vna_pkg::mul_step_type'(cnt_ff[3:0]);
            end
            if (cnt_ff != 5'd0) begin
               cmd.fold_en   = 1'b1;
               cmd.fold_step = vna_pkg::mul_step_type'(cnt_ff[3:0] - 4'd1);
            end
            if (cnt_ff == 5'd6) begin
               k_in     = '0;
               state_in = S_ACC_RD;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_ACC_RD: begin
            cmd.acc_rd   = 1'b1;
            cmd.addr_sel = vna_pkg::corner_sel(k_ff);
            state_in     = S_ACC_WR;
         end
         S_ACC_WR: begin
            cmd.acc_wr   = 1'b1;
            cmd.addr_sel = vna_pkg::corner_sel(k_ff);
            if (k_ff == 2'd2) begin
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_ACC_RD;
            end
         end
         S_N_RD: begin
            cmd.acc_rd   = 1'b1;
            cmd.addr_sel = vna_pkg::ADDR_VIDX;
            state_in     = S_N_MAG;
         end
         S_N_MAG: begin
            cmd.mag_load = 1'b1;
            state_in     = S_N_SHIFT;
         end
         S_N_SHIFT: begin
            if (status.mag_big) begin
               cmd.shift_en = 1'b1;
            end else begin
               cnt_in   = '0;
               state_in = S_N_SQ;
            end
         end
         S_N_SQ: begin
            if (cnt_ff < 5'd3) begin
               cmd.mul_en   = 1'b1;
               cmd.mul_step = vna_pkg::mul_step_type'(4'(vna_pkg::MS_SQX) + cnt_ff[3:0]);
            end
            if (cnt_ff != 5'd0) begin
               cmd.fold_en   = 1'b1;
               cmd.fold_step =
                  vna_pkg::mul_step_type'(4'(vna_pkg::MS_SQX) + cnt_ff[3:0] - 4'd1);
            end
            if (cnt_ff == 5'd3) begin
               state_in = S_N_CHK;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_N_CHK: begin
            if (status.sum_zero) begin
               cmd.rsp_zero = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.sqrt_init = 1'b1;
               cnt_in        = '0;
               state_in      = S_N_SQRT;
            end
         end
         S_N_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == 5'd31) begin
               k_in     = '0;
               state_in = S_DIV_INIT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cmd.div_comp = k_ff;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 5'd15) begin
               state_in = S_DIV_STORE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_DIV_STORE: begin
            cmd.div_store = 1'b1;
            cmd.div_comp  = k_ff;
            if (k_ff == 2'd2) begin
               state_in = S_N_OUT;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_DIV_INIT;
            end
         end
         S_N_OUT: begin
            cmd.rsp_emit = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/vertex_normal_accumulator_unit.sv =====
// Top level of the vertex normal accumulator: controller plus datapath.
// Uses vna_pkg, vna_controller, vna_datapath (which holds two vna_ram).
//
//   channel   ports                      transfer when
//   request   start, busy, req_item      start high and busy low at the edge
//   result    rsp_strobe, rsp_item       rsp_strobe high (one cycle, no stall)
//
// Load vertex: busy stays low. Triangle: three position reads, six multiplies
// on one shared multiplier, three read-modify-writes. Read normal: a right
// shift of up to 36 bits (one bit per cycle), 32 square-root steps and three
// 16-step divides, then the result is strobed from the result register.
// Synchronous reset clears only control; stores are undefined until written.
`default_nettype none

module vertex_normal_accumulator_unit #(
   parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire vna_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output vna_pkg::rsp_type      rsp_item
);

   vna_pkg::cmd_type    cmd;
   vna_pkg::status_type status;

   vna_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_item.mode),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   vna_datapath #(.VERTEX_COUNT(VERTEX_COUNT)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for vertex_normal_accumulator_unit: drives loads, triangles,
// normal reads and unused mode codes, predicts the normalized normals and
// checks each result. Depends on vna_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_top;

   localparam int VCNT = 1024;
   localparam int WATCHDOG_LIMIT = 20000;
   // unused mode code: the block must ignore it
   localparam logic [1:0] MODE_NOP = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   vna_pkg::req_type req_item = '0;
   logic             rsp_strobe;
   vna_pkg::rsp_type rsp_item;

   vertex_normal_accumulator_unit #(.VERTEX_COUNT(VCNT)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state
   logic signed [23:0] px [VCNT];
   logic signed [23:0] py [VCNT];
   logic signed [23:0] pz [VCNT];
   logic signed [59:0] nacc_x [VCNT];
   logic signed [59:0] nacc_y [VCNT];
   logic signed [59:0] nacc_z [VCNT];
   bit                 loaded [VCNT];

   vna_pkg::rsp_type normals_due[$];
   int      mismatches = 0;
   int      n_items = 0, n_reads = 0, n_zero = 0;
   int      idle_cycles = 0;

   function automatic logic signed [59:0] sat_sum(logic signed [59:0] a,
                                                 logic signed [49:0] d);
      logic signed [61:0] s;
      s = 62'(a) + 62'(d);
      if (s > 62'sh07FF_FFFF_FFFF_FFFF) return 60'sh7FF_FFFF_FFFF_FFFF;
      if (s < -62'sh0800_0000_0000_0000) return 60'sh800_0000_0000_0000;
      return s[59:0];
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic vna_pkg::rsp_type unit_normal(logic [9:0] vi);
      vna_pkg::rsp_type r;
      logic [63:0] m[3], big, s, len, q;
      logic signed [59:0] a[3];
      r = '0;
      r.zero_length = 1'b1;
      if (vi >= VCNT) return r;
      a[0] = nacc_x[vi]; a[1] = nacc_y[vi]; a[2] = nacc_z[vi];
      for (int k = 0; k < 3; k++) m[k] = a[k] < 0 ? 64'(-66'(a[k])) : 64'(a[k]);
      big = m[0];
      if (m[1] > big) big = m[1];
      if (m[2] > big) big = m[2];
      while (big >= (64'd1 << 24)) begin
         big = big >> 1;
         for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
      end
      s = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
      if (s == 0) return r;
      len = int_sqrt(s << 12);
      for (int k = 0; k < 3; k++) begin
         q = ((m[k] << 21) + (len >> 1)) / len;
         if (q > 32767) q = 32767;
         if (a[k] < 0) q = -q;
         case (k)
            0: r.normal_x = q[15:0];
            1: r.normal_y = q[15:0];
            default: r.normal_z = q[15:0];
         endcase
      end
      r.zero_length = 1'b0;
      return r;
   endfunction

   task automatic apply_item(vna_pkg::req_type it);
      logic signed [24:0] s1x, s1y, s1z, s2x, s2y, s2z;
      logic signed [49:0] nx, ny, nz;
      logic [9:0] c[3];
      case (it.mode)
         vna_pkg::MODE_LOAD: if (it.vertex_index < VCNT) begin
            px[it.vertex_index] = it.pos_x;
            py[it.vertex_index] = it.pos_y;
            pz[it.vertex_index] = it.pos_z;
            nacc_x[it.vertex_index] = 0;
            nacc_y[it.vertex_index] = 0;
            nacc_z[it.vertex_index] = 0;
            loaded[it.vertex_index] = 1'b1;
         end
         vna_pkg::MODE_TRI: begin
            c[0] = it.corner_a; c[1] = it.corner_b; c[2] = it.corner_c;
            if (c[0] < VCNT && c[1] < VCNT && c[2] < VCNT) begin
               s1x = 25'(px[c[2]]) - 25'(px[c[0]]);
               s1y = 25'(py[c[2]]) - 25'(py[c[0]]);
               s1z = 25'(pz[c[2]]) - 25'(pz[c[0]]);
               s2x = 25'(px[c[1]]) - 25'(px[c[0]]);
               s2y = 25'(py[c[1]]) - 25'(py[c[0]]);
               s2z = 25'(pz[c[1]]) - 25'(pz[c[0]]);
               nx = 50'(s1y) * 50'(s2z) - 50'(s1z) * 50'(s2y);
               ny = 50'(s1z) * 50'(s2x) - 50'(s1x) * 50'(s2z);
               nz = 50'(s1x) * 50'(s2y) - 50'(s1y) * 50'(s2x);
               for (int k = 0; k < 3; k++) begin
                  nacc_x[c[k]] = sat_sum(nacc_x[c[k]], nx);
                  nacc_y[c[k]] = sat_sum(nacc_y[c[k]], ny);
                  nacc_z[c[k]] = sat_sum(nacc_z[c[k]], nz);
               end
            end
         end
         vna_pkg::MODE_READ: begin
            normals_due.insert(normals_due.size(), unit_normal(it.vertex_index));
            n_reads++;
         end
         default: ;
      endcase
   endtask

   function automatic vna_pkg::req_type rand_req();
      logic [127:0] raw;
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      return vna_pkg::req_type'(raw[$bits(vna_pkg::req_type)-1:0]);
   endfunction

   // one transfer on the request side, after a random gap; start stays high
   // after the transfer so the next item can follow with no gap
   task automatic send_item(vna_pkg::req_type it, bit allow_gap = 1'b1);
      int gap;
      gap = allow_gap && $urandom_range(0, 2) == 0 ? int'($urandom_range(0, 12)) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_item(it);
      n_items++;
   endtask

   task automatic send_load(logic [9:0] vi, logic [23:0] x, logic [23:0] y,
                            logic [23:0] z);
      vna_pkg::req_type it;
      it = rand_req();
      it.mode = vna_pkg::MODE_LOAD; it.vertex_index = vi;
      it.pos_x = x; it.pos_y = y; it.pos_z = z;
      send_item(it);
   endtask

   task automatic send_tri(logic [9:0] a, logic [9:0] b, logic [9:0] c);
      vna_pkg::req_type it;
      it = rand_req();
      it.mode = vna_pkg::MODE_TRI; it.corner_a = a; it.corner_b = b; it.corner_c = c;
      send_item(it);
   endtask

   task automatic send_read(logic [9:0] vi);
      vna_pkg::req_type it;
      it = rand_req();
      it.mode = vna_pkg::MODE_READ; it.vertex_index = vi;
      send_item(it);
   endtask

   function automatic logic [9:0] pick_loaded();
      logic [9:0] v;
      do v = 10'($urandom_range(0, VCNT - 1)); while (!loaded[v]);
      return v;
   endfunction

   function automatic logic [23:0] rand_pos();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         1: return 24'($signed($urandom_range(0, 8192)) - 4096);
         default: return 24'($urandom());
      endcase
   endfunction

   // release the request side and wait for every pending normal
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (normals_due.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      vna_pkg::rsp_type exp_n;
      if (!reset && rsp_strobe) begin
         if (normals_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected normal %h", rsp_item);
         end else begin
            exp_n = normals_due.pop_front();
            if (exp_n.zero_length) n_zero++;
            if (rsp_item !== exp_n) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: normal exp x=%0d y=%0d z=%0d zl=%b got x=%0d y=%0d z=%0d zl=%b",
                           exp_n.normal_x, exp_n.normal_y, exp_n.normal_z,
                           exp_n.zero_length, rsp_item.normal_x, rsp_item.normal_y,
                           rsp_item.normal_z, rsp_item.zero_length);
            end
         end
      end
   end

   // watchdog: cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic test_edges();
      // extreme positions: cross products reach full width
      send_load(0, 24'h800000, 24'h800000, 24'h800000);
      send_load(1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      send_load(2, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
      send_load(1023, 24'h000000, 24'h000000, 24'h000000);
      send_read(0);       // cleared accumulator: zero length
      send_tri(0, 1, 2);
      send_read(0);
      send_read(1);
      for (int i = 0; i < 8; i++) send_tri(0, 1, 2);
      send_read(2);       // large values: wide shift
      send_tri(0, 0, 1);  // degenerate
      send_tri(1023, 0, 1);
      send_read(1023);
      drain();
   endtask

   task automatic test_saturation();
      // repeated max-area triangles: accumulators grow far past 24 bits
      send_load(3, 24'h800000, 24'h800000, 24'h000000);
      send_load(4, 24'h7FFFFF, 24'h800000, 24'h000000);
      send_load(5, 24'h800000, 24'h7FFFFF, 24'h000000);
      for (int i = 0; i < 700; i++) send_tri(3, 4, 5);
      send_read(3);
      send_tri(3, 5, 4);
      send_read(4);
      drain();
   endtask

   task automatic test_ignored();
      vna_pkg::req_type it;
      it = rand_req();
      it.mode = MODE_NOP;
      send_item(it);
      drain();
      // sender holds off until every normal is back
      send_read(pick_loaded());
      drain();
      repeat (200) @(posedge clock);
   endtask

   task automatic test_random(int count);
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = int'($urandom_range(0, 99));
         if (sel < 25)
            send_load(10'($urandom_range(0, 63)), rand_pos(), rand_pos(), rand_pos());
         else if (sel < 65)
            send_tri(pick_loaded(), pick_loaded(), pick_loaded());
         else if (sel < 97) send_read(pick_loaded());
         else begin
            vna_pkg::req_type it;
            it = rand_req();
            it.mode = MODE_NOP;
            send_item(it);
         end
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges();
      test_ignored();
      test_random(350);
      test_saturation();
      test_random(350);
      drain();
      repeat (200) @(posedge clock);
      $display("Covered %0d transfers, %0d normal reads (%0d zero length).",
               n_items, n_reads, n_zero);
      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/vna_pkg.sv
hdl/vna_ram.sv
hdl/vna_datapath.sv
hdl/vna_controller.sv
hdl/vertex_normal_accumulator_unit.sv
tb/sv/tb_top.sv
